FILE: hdl/rotated_sprite_blitter_defines.svh
// Assertion macros shared by the rotated sprite blitter modules.
`ifndef ROTATED_SPRITE_BLITTER_DEFINES_SVH
`define ROTATED_SPRITE_BLITTER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define RSB_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle.
`define RSB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Check that a condition never occurs.
`define RSB_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

FILE: hdl/rsb_pkg.sv
// Shared types, constants and register codes of the rotated sprite blitter.
package rsb_pkg;

   // Field widths
   localparam int unsigned SIZE_W     = 7;
   localparam int unsigned CX_W       = 11;
   localparam int unsigned CY_W       = 10;
   localparam int unsigned COEF_W     = 16;
   localparam int unsigned COLOUR_W   = 24;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // Parameter defaults
   localparam int unsigned SCREEN_WIDTH_DEF   = 1280;
   localparam int unsigned SCREEN_HEIGHT_DEF  = 1024;
   localparam int unsigned SPRITE_MAX_DEF     = 64;
   localparam int unsigned COEF_FRAC_BITS_DEF = 14;
   localparam int unsigned QUEUE_DEPTH        = 2;

   localparam logic [COLOUR_W-1:0] TRANSPARENT_COLOUR = 24'h000000;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPR_COLS      = 3'd0,
      CSR_SPR_ROWS      = 3'd1,
      CSR_CENTRE_X      = 3'd2,
      CSR_CENTRE_Y      = 3'd3,
      CSR_COS_ANGLE     = 3'd4,
      CSR_SIN_ANGLE     = 3'd5,
      CSR_CLEAR_MODE    = 3'd6
   } rsb_csr_index_type;

   typedef struct packed {
      logic [SIZE_W-1:0]        spr_cols;
      logic [SIZE_W-1:0]        spr_rows;
      logic [CX_W-1:0]          centre_x;
      logic [CY_W-1:0]          centre_y;
      logic signed [COEF_W-1:0] cos_angle;
      logic signed [COEF_W-1:0] sin_angle;
      logic                     clear_mode;
   } rsb_cfg_type;

   localparam rsb_cfg_type CFG_RESET = '{
      spr_cols:      7'd30,
      spr_rows:      7'd30,
      centre_x:      11'd0,
      centre_y:      10'd0,
      cos_angle:     16'sd16384,
      sin_angle:     16'sd0,
      clear_mode:    1'b0
   };

endpackage

FILE: hdl/rsb_channels.sv
// Handshake channel interfaces: pixel requests, write responses, register writes.
interface rsb_req_if;
   logic                          valid;
   logic                          ready;
   logic [rsb_pkg::COLOUR_W-1:0]  pixel_colour;

   modport source (output valid, output pixel_colour, input ready);
   modport sink   (input valid, input pixel_colour, output ready);
endinterface

interface rsb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          write_valid;
   logic [rsb_pkg::CX_W-1:0]      pos_x;
   logic [rsb_pkg::CY_W-1:0]      pos_y;
   logic [rsb_pkg::COLOUR_W-1:0]  write_colour;
   logic                          copy_background;
   logic                          last_pixel;

   modport source (output valid, output write_valid, output pos_x, output pos_y,
                   output write_colour, output copy_background, output last_pixel,
                   input ready);
   modport sink   (input valid, input write_valid, input pos_x, input pos_y,
                   input write_colour, input copy_background, input last_pixel,
                   output ready);
endinterface

interface rsb_csr_if;
   logic                            valid;
   logic                            ready;
   logic [rsb_pkg::CSR_IDX_W-1:0]   wr_index;
   logic [rsb_pkg::CSR_DATA_W-1:0]  wr_data;

   modport source (output valid, output wr_index, output wr_data, input ready);
   modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

FILE: hdl/rsb_front.sv
// Front end: accepts pixels, tracks the raster position and classifies each pixel.
`include "rotated_sprite_blitter_defines.svh"

module rsb_front #(
   parameter int unsigned SPRITE_MAX = rsb_pkg::SPRITE_MAX_DEF,
   localparam int unsigned DW = $clog2(SPRITE_MAX) + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rsb_pkg::rsb_cfg_type          cfg,
   rsb_req_if.sink                       req_chan,
   output logic                          push_valid,
   input  logic                          push_ready,
   output logic signed [DW-1:0]          dx,
   output logic signed [DW-1:0]          dy,
   output logic [rsb_pkg::COLOUR_W-1:0]  colour,
   output logic                          keep,
   output logic                          last
);
   import rsb_pkg::*;

   localparam int unsigned CW   = DW - 1;
   localparam int unsigned SZ_W = (DW > SIZE_W) ? DW : SIZE_W;

   logic [SZ_W-1:0] w_lim;
   logic [SZ_W-1:0] h_lim;
   logic [CW-1:0]   col_ff, col_in;
   logic [CW-1:0]   row_ff, row_in;
   logic            col_end;
   logic            row_end;
   logic            accept;

   // Force a programmed size into 1..SPRITE_MAX
   function automatic logic [SZ_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [SZ_W-1:0] ext;
      ext = SZ_W'(v);
      if (ext == '0)
         return SZ_W'(1);
      else if (ext > SZ_W'(SPRITE_MAX))
         return SZ_W'(SPRITE_MAX);
      else
         return ext;
   endfunction

   assign w_lim = clamp_size(cfg.spr_cols);
   assign h_lim = clamp_size(cfg.spr_rows);

   // Wrap as soon as a counter reaches or passes its limit
   assign col_end = ({1'b0, col_ff} + (CW + 1)'(1)) >= w_lim[CW:0];
   assign row_end = ({1'b0, row_ff} + (CW + 1)'(1)) >= h_lim[CW:0];

   // Offset from the sprite centre, half size rounded down
   assign dx = $signed({1'b0, col_ff}) - $signed({1'b0, w_lim[CW:1]});
   assign dy = $signed({1'b0, row_ff}) - $signed({1'b0, h_lim[CW:1]});

   assign colour = req_chan.pixel_colour;
   assign keep   = cfg.clear_mode || (req_chan.pixel_colour != TRANSPARENT_COLOUR);
   assign last   = col_end && row_end;

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;

   // Advance the raster position on each accepted transaction
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + CW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   `RSB_ASSERT_NEXT(a_col_wrap, accept && col_end, col_ff == '0, "column did not wrap")
   `RSB_ASSERT_NEXT(a_col_step, accept && !col_end, col_ff == $past(col_ff) + CW'(1), "no step")
   `RSB_ASSERT_NEXT(a_row_hold, accept && !col_end, $stable(row_ff), "row moved mid-line")
   `RSB_ASSERT_NEXT(a_row_wrap, accept && last, row_ff == '0, "row did not wrap on last pixel")

endmodule

FILE: hdl/rsb_queue.sv
// Small FIFO that decouples the front end from the transform pipeline.
`include "rotated_sprite_blitter_defines.svh"

module rsb_queue #(
   parameter int unsigned DATA_W = 8,
   parameter int unsigned DEPTH  = rsb_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  logic [DATA_W-1:0] wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output logic [DATA_W-1:0] rd_data
);
   import rsb_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;

   assign wr_ready = count_ff != CNT_W'(DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // Advance pointers with explicit wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop)
         count_in = count_ff + CNT_W'(1);
      else if (pop && !push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming transaction
   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= wr_data;
   end

   `RSB_ASSERT_NEVER(a_q_over, count_ff > CNT_W'(DEPTH), "queue fill above depth")
   `RSB_ASSERT_NEXT(a_q_inc, push && !pop, count_ff == $past(count_ff) + CNT_W'(1), "fill did not grow")
   `RSB_ASSERT_NEXT(a_q_dec, pop && !push, count_ff == $past(count_ff) - CNT_W'(1), "fill did not shrink")

endmodule

FILE: hdl/rsb_back.sv
// Back end: rotates the offset, adds the centre, clips and forms the write transaction.
`include "rotated_sprite_blitter_defines.svh"

module rsb_back #(
   parameter int unsigned SCREEN_WIDTH   = rsb_pkg::SCREEN_WIDTH_DEF,
   parameter int unsigned SCREEN_HEIGHT  = rsb_pkg::SCREEN_HEIGHT_DEF,
   parameter int unsigned SPRITE_MAX     = rsb_pkg::SPRITE_MAX_DEF,
   parameter int unsigned COEF_FRAC_BITS = rsb_pkg::COEF_FRAC_BITS_DEF,
   localparam int unsigned DW     = $clog2(SPRITE_MAX) + 1,
   localparam int unsigned ITEM_W = 2 * DW + rsb_pkg::COLOUR_W + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rsb_pkg::rsb_cfg_type cfg,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  logic [ITEM_W-1:0]    item,
   rsb_rsp_if.source            rsp_chan
);
   import rsb_pkg::*;

   localparam int unsigned F  = COEF_FRAC_BITS;
   localparam int unsigned PW = DW + COEF_W;
   localparam int unsigned AW = (((12 + F) > (PW + 1)) ? (12 + F) : (PW + 1)) + 1;
   localparam int unsigned TW = AW - F;

   logic signed [DW-1:0]  i_dx;
   logic signed [DW-1:0]  i_dy;
   logic [COLOUR_W-1:0]   i_colour;
   logic                  i_keep;
   logic                  i_last;
   logic                  en;

   // Stage 1: products
   logic                  s1_valid_ff;
   logic signed [PW-1:0]  p_xc_ff, p_xc_in;
   logic signed [PW-1:0]  p_ys_ff, p_ys_in;
   logic signed [PW-1:0]  p_xs_ff, p_xs_in;
   logic signed [PW-1:0]  p_yc_ff, p_yc_in;
   logic [COLOUR_W-1:0]   colour_s1_ff;
   logic                  keep_s1_ff;
   logic                  last_s1_ff;

   // Stage 2: sums
   logic                  s2_valid_ff;
   logic signed [AW-1:0]  acc_x_ff, acc_x_in;
   logic signed [AW-1:0]  acc_y_ff, acc_y_in;
   logic [COLOUR_W-1:0]   colour_s2_ff;
   logic                  keep_s2_ff;
   logic                  last_s2_ff;

   // Stage 3: truncate, clip and output register
   logic [AW-1:0]         biased_x, biased_y;
   logic signed [TW-1:0]  t_x, t_y;
   logic                  on_screen;
   logic                  wv;
   logic                  rsp_valid_ff;
   logic                  write_valid_ff, write_valid_in;
   logic [CX_W-1:0]       pos_x_ff, pos_x_in;
   logic [CY_W-1:0]       pos_y_ff, pos_y_in;
   logic [COLOUR_W-1:0]   write_colour_ff, write_colour_in;
   logic                  copy_background_ff, copy_background_in;
   logic                  last_pixel_ff;
   logic                  out_clean;

   assign {i_dx, i_dy, i_colour, i_keep, i_last} = item;

   // Advance the whole pipeline unless a finished result is held
   assign en         = !rsp_valid_ff || rsp_chan.ready;
   assign item_ready = en;

   assign p_xc_in = i_dx * $signed(cfg.cos_angle);
   assign p_ys_in = i_dy * $signed(cfg.sin_angle);
   assign p_xs_in = i_dx * $signed(cfg.sin_angle);
   assign p_yc_in = i_dy * $signed(cfg.cos_angle);

   assign acc_x_in = $signed({{(AW - CX_W - F){1'b0}}, cfg.centre_x, {F{1'b0}}})
                     + AW'(p_xc_ff) - AW'(p_ys_ff);
   assign acc_y_in = $signed({{(AW - CY_W - F){1'b0}}, cfg.centre_y, {F{1'b0}}})
                     + AW'(p_xs_ff) + AW'(p_yc_ff);

   // Truncate toward zero: bias negative sums before the arithmetic shift
   assign biased_x = acc_x_ff + {{TW{1'b0}}, {F{acc_x_ff[AW-1]}}};
   assign biased_y = acc_y_ff + {{TW{1'b0}}, {F{acc_y_ff[AW-1]}}};
   assign t_x      = biased_x[AW-1:F];
   assign t_y      = biased_y[AW-1:F];

   assign on_screen = !t_x[TW-1] && (32'(t_x[TW-2:0]) < SCREEN_WIDTH) &&
                      !t_y[TW-1] && (32'(t_y[TW-2:0]) < SCREEN_HEIGHT);
   assign wv        = on_screen && keep_s2_ff;

   assign write_valid_in     = wv;
   assign pos_x_in           = wv ? t_x[CX_W-1:0] : '0;
   assign pos_y_in           = wv ? t_y[CY_W-1:0] : '0;
   assign write_colour_in    = (wv && !cfg.clear_mode) ? colour_s2_ff : '0;
   assign copy_background_in = wv && cfg.clear_mode;

   // Clear valid flags under reset and advance them when the pipeline is enabled
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= item_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // Advance payload through the stages
   always_ff @(posedge clock) begin
      if (en) begin
         p_xc_ff            <= p_xc_in;
         p_ys_ff            <= p_ys_in;
         p_xs_ff            <= p_xs_in;
         p_yc_ff            <= p_yc_in;
         colour_s1_ff       <= i_colour;
         keep_s1_ff         <= i_keep;
         last_s1_ff         <= i_last;
         acc_x_ff           <= acc_x_in;
         acc_y_ff           <= acc_y_in;
         colour_s2_ff       <= colour_s1_ff;
         keep_s2_ff         <= keep_s1_ff;
         last_s2_ff         <= last_s1_ff;
         write_valid_ff     <= write_valid_in;
         pos_x_ff           <= pos_x_in;
         pos_y_ff           <= pos_y_in;
         write_colour_ff    <= write_colour_in;
         copy_background_ff <= copy_background_in;
         last_pixel_ff      <= last_s2_ff;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.write_valid     = write_valid_ff;
   assign rsp_chan.pos_x           = pos_x_ff;
   assign rsp_chan.pos_y           = pos_y_ff;
   assign rsp_chan.write_colour    = write_colour_ff;
   assign rsp_chan.copy_background = copy_background_ff;
   assign rsp_chan.last_pixel      = last_pixel_ff;

   // Fields other than last_pixel are zero in a result without a write
   assign out_clean = (pos_x_ff == '0) && (pos_y_ff == '0) &&
                      (write_colour_ff == '0) && !copy_background_ff;

   `RSB_ASSERT_IMPLIES(a_nowrite_zero, rsp_valid_ff && !write_valid_ff, out_clean, "stray fields")
   `RSB_ASSERT_NEVER(a_mode_excl, rsp_valid_ff && copy_background_ff && |write_colour_ff, "copy+colour")
   `RSB_ASSERT_NEXT(a_stall_valid, !en, $stable(s2_valid_ff), "valid moved under stall")
   `RSB_ASSERT_NEXT(a_stall_hold, !en && s2_valid_ff, $stable({acc_x_ff, acc_y_ff}), "sums moved")

endmodule

FILE: hdl/rotated_sprite_blitter.sv
// Top level of the rotated sprite blitter: register file, front end, queue, back end.
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    pixel_colour
//   rsp_chan  out  valid/ready    write_valid, pos_x, pos_y, write_colour,
//                                 copy_background, last_pixel
//   csr_chan  in   valid/ready    wr_index, wr_data (ready always high)
//
// One transaction per cycle is accepted and one result leaves per cycle when the
// sink keeps ready high. A pixel passes through the queue, then the product, sum
// and clip stages, before its result appears. A stalled result holds the
// three stages; the two-entry queue keeps taking pixels until it fills.
// Reset loads the register defaults and clears the raster counters at once.
module rotated_sprite_blitter #(
   parameter int unsigned SCREEN_WIDTH   = rsb_pkg::SCREEN_WIDTH_DEF,
   parameter int unsigned SCREEN_HEIGHT  = rsb_pkg::SCREEN_HEIGHT_DEF,
   parameter int unsigned SPRITE_MAX     = rsb_pkg::SPRITE_MAX_DEF,
   parameter int unsigned COEF_FRAC_BITS = rsb_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rsb_req_if.sink     req_chan,
   rsb_rsp_if.source   rsp_chan,
   rsb_csr_if.sink     csr_chan
);
   import rsb_pkg::*;

   localparam int unsigned DW     = $clog2(SPRITE_MAX) + 1;
   localparam int unsigned ITEM_W = 2 * DW + COLOUR_W + 2;

   rsb_cfg_type           cfg_ff, cfg_in;
   logic                  push_valid;
   logic                  push_ready;
   logic signed [DW-1:0]  f_dx;
   logic signed [DW-1:0]  f_dy;
   logic [COLOUR_W-1:0]   f_colour;
   logic                  f_keep;
   logic                  f_last;
   logic [ITEM_W-1:0]     q_wr_data;
   logic [ITEM_W-1:0]     q_rd_data;
   logic                  q_rd_valid;
   logic                  q_rd_ready;

   assign csr_chan.ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (rsb_csr_index_type'(csr_chan.wr_index))
            CSR_SPR_COLS:      cfg_in.spr_cols      = csr_chan.wr_data[SIZE_W-1:0];
            CSR_SPR_ROWS:      cfg_in.spr_rows      = csr_chan.wr_data[SIZE_W-1:0];
            CSR_CENTRE_X:      cfg_in.centre_x      = csr_chan.wr_data[CX_W-1:0];
            CSR_CENTRE_Y:      cfg_in.centre_y      = csr_chan.wr_data[CY_W-1:0];
            CSR_COS_ANGLE:     cfg_in.cos_angle     = $signed(csr_chan.wr_data[COEF_W-1:0]);
            CSR_SIN_ANGLE:     cfg_in.sin_angle     = $signed(csr_chan.wr_data[COEF_W-1:0]);
            CSR_CLEAR_MODE:    cfg_in.clear_mode    = csr_chan.wr_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         cfg_ff <= CFG_RESET;
      else
         cfg_ff <= cfg_in;
   end

   rsb_front #(
      .SPRITE_MAX (SPRITE_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .dx         (f_dx),
      .dy         (f_dy),
      .colour     (f_colour),
      .keep       (f_keep),
      .last       (f_last)
   );

   assign q_wr_data = {f_dx, f_dy, f_colour, f_keep, f_last};

   rsb_queue #(
      .DATA_W (ITEM_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_data  (q_wr_data),
      .rd_valid (q_rd_valid),
      .rd_ready (q_rd_ready),
      .rd_data  (q_rd_data)
   );

   rsb_back #(
      .SCREEN_WIDTH   (SCREEN_WIDTH),
      .SCREEN_HEIGHT  (SCREEN_HEIGHT),
      .SPRITE_MAX     (SPRITE_MAX),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (q_rd_valid),
      .item_ready (q_rd_ready),
      .item       (q_rd_data),
      .rsp_chan   (rsp_chan)
   );

endmodule
